// ===== src/rns_basis_conversion_accumulate_assert.svh =====
// assertion macros for the rns basis conversion block
// expects clk and arst_n in the scope of the including module
`ifndef RNS_BASIS_CONVERSION_ACCUMULATE_ASSERT_SVH
`define RNS_BASIS_CONVERSION_ACCUMULATE_ASSERT_SVH

`ifndef SYNTHESIS
`define RBCA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");
`define RBCA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");
`else
`define RBCA_ASSERT_IMPL(label, ante, cons)
`define RBCA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/rbca_pkg.sv =====
// shared types, constants and helpers for the rns basis conversion block
// no dependencies
package rbca_pkg;

	localparam int unsigned DATA_W = 61;
	localparam int unsigned WIDE_W = 128;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned PP_W = 2 * HALF_W;
	localparam int unsigned PROD_W = 2 * DATA_W;
	localparam int unsigned STEP_W = 8;
	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 64;

	localparam logic [STEP_W-1:0] PROD_STEPS = STEP_W'(PROD_W);
	localparam logic [STEP_W-1:0] ACC_STEPS = STEP_W'(WIDE_W);

	localparam logic REG_DST = 1'b0;
	localparam logic [DATA_W-1:0] DST_RESET = DATA_W'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_RED1,
		ST_MUL2,
		ST_RED2,
		ST_OUT
	} state_t;

	// partial product select: {a half, b half}
	typedef enum logic [1:0] {
		PP_LL,
		PP_LH,
		PP_HL,
		PP_HH
	} pp_sel_t;

	typedef struct packed {
		logic            vld;
		pp_sel_t         sel;
		logic [PP_W-1:0] pp;
	} pp_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} red_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} red_sts_t;

	function automatic logic [WIDE_W-1:0] pp_align(input pp_t p);
		logic [WIDE_W-1:0] r;
		case (p.sel)
			PP_LL: r = {{(WIDE_W-PP_W){1'b0}}, p.pp};
			PP_LH, PP_HL: r = {{(WIDE_W-PP_W-HALF_W){1'b0}}, p.pp, {HALF_W{1'b0}}};
			PP_HH: r = {p.pp, {(WIDE_W-PP_W){1'b0}}};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/rns_basis_conversion_accumulate.sv =====
// top level of the rns fast basis conversion accumulator: sequencer, apb register
// depends on rbca_pkg, rbca_mul, rbca_mod and the assertion macro header
`include "rns_basis_conversion_accumulate_assert.svh"

// One word carries a residue x, its source prime p, w (inverse punctured product
// mod p) and m (punctured product mod the destination prime q). The block forms
// (x*w mod p)*m and adds it to a 128-bit accumulator that wraps; on a word marked
// last it returns the accumulator mod q and clears it. in_ready is high only while
// the sequencer is idle, so a word is taken only once the previous word is through:
// four 32x32 partial products for x*w, a 122-step bit-serial reduction by p, and
// four more for the product with m. A word marked last adds a 128-step reduction
// by q, and its result and the next word wait while out_ready is low and a
// previous result is still held. A zero p gives a zero term, a zero q gives a
// zero result. dst_modulus sits at byte address 0 (64-bit data); write it only
// while the block is idle.
module rns_basis_conversion_accumulate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rbca_pkg::APB_AW-1:0] paddr,
	input  logic [rbca_pkg::APB_DW-1:0] pwdata,
	output logic [rbca_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rbca_pkg::DATA_W-1:0] residue,
	input  logic [rbca_pkg::DATA_W-1:0] src_modulus,
	input  logic [rbca_pkg::DATA_W-1:0] inv_punch,
	input  logic [rbca_pkg::DATA_W-1:0] others_prod,
	input  logic                        last_term,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rbca_pkg::DATA_W-1:0] converted
);

	rbca_pkg::state_t            state_q, state_d;
	logic [rbca_pkg::DATA_W-1:0] dst_q, p_q, m_q, out_q, mul_a, mul_b, red_rem;
	logic                        p_zero_q, last_q, out_vld_q;
	logic [rbca_pkg::WIDE_W-1:0] wide_q, acc_q, term, wide_sum, acc_sum, red_div;
	logic                        mul_start, out_load, cfg_wr, pp_last;
	rbca_pkg::pp_t               pp;
	rbca_pkg::red_req_t          red_req;
	rbca_pkg::red_sts_t          red_sts;

	rbca_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.pp     (pp)
	);

	rbca_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (red_req),
		.dividend (red_div),
		.modulus  (state_q == rbca_pkg::ST_MUL1 ? (p_zero_q ? dst_q : p_q) : dst_q),
		.sts      (red_sts),
		.rem      (red_rem)
	);

	// apb register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[rbca_pkg::APB_AW-1] == rbca_pkg::REG_DST);
	assign prdata = (paddr[rbca_pkg::APB_AW-1] == rbca_pkg::REG_DST)
		? {{(rbca_pkg::APB_DW-rbca_pkg::DATA_W){1'b0}}, dst_q} : '0;

	assign term     = rbca_pkg::pp_align(pp);
	assign wide_sum = wide_q + term;
	assign acc_sum  = acc_q + term;
	assign pp_last  = pp.vld && (pp.sel == rbca_pkg::PP_HH);

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		mul_start     = 1'b0;
		mul_a         = residue;
		mul_b         = inv_punch;
		red_req.start = 1'b0;
		red_req.steps = rbca_pkg::PROD_STEPS;
		red_div       = {wide_sum[rbca_pkg::PROD_W-1:0],
			{(rbca_pkg::WIDE_W-rbca_pkg::PROD_W){1'b0}}};
		out_load      = 1'b0;
		case (state_q)
			rbca_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mul_start = 1'b1;
					state_d   = rbca_pkg::ST_MUL1;
				end
			end
			rbca_pkg::ST_MUL1: begin
				if (pp_last) begin
					red_req.start = 1'b1;
					state_d       = rbca_pkg::ST_RED1;
				end
			end
			rbca_pkg::ST_RED1: begin
				mul_a = p_zero_q ? '0 : red_rem;
				mul_b = m_q;
				if (red_sts.done) begin
					mul_start = 1'b1;
					state_d   = rbca_pkg::ST_MUL2;
				end
			end
			rbca_pkg::ST_MUL2: begin
				red_req.steps = rbca_pkg::ACC_STEPS;
				red_div       = acc_sum;
				if (pp_last) begin
					if (last_q) begin
						red_req.start = 1'b1;
						state_d       = rbca_pkg::ST_RED2;
					end else begin
						state_d = rbca_pkg::ST_IDLE;
					end
				end
			end
			rbca_pkg::ST_RED2: begin
				if (red_sts.done) begin
					state_d = rbca_pkg::ST_OUT;
				end
			end
			rbca_pkg::ST_OUT: begin
				if (!out_vld_q || out_ready) begin
					out_load = 1'b1;
					state_d  = rbca_pkg::ST_IDLE;
				end
			end
			default: state_d = rbca_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rbca_pkg::ST_IDLE;
			dst_q     <= rbca_pkg::DST_RESET;
			acc_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				dst_q <= pwdata[rbca_pkg::DATA_W-1:0];
			end
			if (state_q == rbca_pkg::ST_MUL2 && pp.vld) begin
				acc_q <= (pp_last && last_q) ? '0 : acc_sum;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			p_q      <= src_modulus;
			p_zero_q <= (src_modulus == '0);
			m_q      <= others_prod;
			last_q   <= last_term;
			wide_q   <= '0;
		end else if (state_q == rbca_pkg::ST_MUL1 && pp.vld) begin
			wide_q <= wide_sum;
		end
		if (out_load) begin
			out_q <= (dst_q == '0) ? '0 : red_rem;
		end
	end

	assign out_valid = out_vld_q;
	assign converted = out_q;

	`RBCA_ASSERT_IMPL(a_idle_no_pp, in_ready, !pp.vld && !red_sts.busy)
	`RBCA_ASSERT_NEXT(a_accept_mul, in_valid && in_ready, state_q == rbca_pkg::ST_MUL1)
	`RBCA_ASSERT_IMPL(a_done_in_red, red_sts.done,
		state_q == rbca_pkg::ST_RED1 || state_q == rbca_pkg::ST_RED2)
	`RBCA_ASSERT_IMPL(a_acc_cleared, state_q == rbca_pkg::ST_RED2, acc_q == '0)

endmodule

// ===== src/rbca_mul.sv =====
// 61x61 multiplier built from one 32x32 multiplier, one partial product a cycle
// depends on rbca_pkg
module rbca_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rbca_pkg::DATA_W-1:0] a,
	input  logic [rbca_pkg::DATA_W-1:0] b,
	output rbca_pkg::pp_t              pp
);

	logic [rbca_pkg::DATA_W-1:0] a_q, b_q;
	rbca_pkg::pp_sel_t           sel_q, sel_s1;
	logic                        busy_q, vld_s1;
	logic [rbca_pkg::HALF_W-1:0] a_half, b_half;
	logic [rbca_pkg::PP_W-1:0]   pp_s1;

	always_comb begin
		a_half = sel_q[1] ? {{(rbca_pkg::HALF_W*2-rbca_pkg::DATA_W){1'b0}},
			a_q[rbca_pkg::DATA_W-1:rbca_pkg::HALF_W]} : a_q[rbca_pkg::HALF_W-1:0];
		b_half = sel_q[0] ? {{(rbca_pkg::HALF_W*2-rbca_pkg::DATA_W){1'b0}},
			b_q[rbca_pkg::DATA_W-1:rbca_pkg::HALF_W]} : b_q[rbca_pkg::HALF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sel_q  <= rbca_pkg::PP_LL;
			sel_s1 <= rbca_pkg::PP_LL;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= busy_q;
			sel_s1 <= sel_q;
			if (start) begin
				busy_q <= 1'b1;
				sel_q  <= rbca_pkg::PP_LL;
			end else if (busy_q) begin
				sel_q <= rbca_pkg::pp_sel_t'(sel_q + 2'd1);
				if (sel_q == rbca_pkg::PP_HH) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		pp_s1 <= a_half * b_half;
	end

	assign pp.vld = vld_s1;
	assign pp.sel = sel_s1;
	assign pp.pp  = pp_s1;

endmodule

// ===== src/rbca_mod.sv =====
// bit-serial restoring reducer: wide word mod a 61-bit modulus, one bit a cycle
// depends on rbca_pkg
module rbca_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rbca_pkg::red_req_t          req,
	input  logic [rbca_pkg::WIDE_W-1:0] dividend,
	input  logic [rbca_pkg::DATA_W-1:0] modulus,
	output rbca_pkg::red_sts_t          sts,
	output logic [rbca_pkg::DATA_W-1:0] rem
);

	logic [rbca_pkg::WIDE_W-1:0] sh_q;
	logic [rbca_pkg::DATA_W-1:0] m_q, r_q, r_nxt;
	logic [rbca_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q, done_q;
	logic [rbca_pkg::DATA_W:0]   trial, diff;

	always_comb begin
		trial = {r_q, sh_q[rbca_pkg::WIDE_W-1]};
		diff  = trial - {1'b0, m_q};
		r_nxt = (trial >= {1'b0, m_q}) ? diff[rbca_pkg::DATA_W-1:0]
			: trial[rbca_pkg::DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rbca_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q <= dividend;
			m_q  <= modulus;
			r_q  <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[rbca_pkg::WIDE_W-2:0], 1'b0};
			r_q  <= r_nxt;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign rem      = r_q;

endmodule
